[design/rubst_pkg.sv]
// Package for the ray against unit box slab test.
// Holds the beat payload types, queue entry types and fixed-point constants.
// Depends on nothing.
package rubst_pkg;

	localparam int QueueDepth = 4;
	localparam int MagW = 32;
	localparam int FracW = 16;
	localparam int DivSteps = MagW + FracW;
	localparam logic signed [32:0] BoxLo = -33'sd32768;
	localparam logic signed [32:0] BoxHi = 33'sd32768;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] hit_distance;
	} res_t;

	typedef struct packed {
		logic [MagW-1:0] lo_mag;
		logic [MagW-1:0] hi_mag;
		logic [MagW-1:0] dvs;
		logic            lo_neg;
		logic            hi_neg;
		logic            dzero;
		logic            oob;
	} axis_job_t;

	typedef struct packed {
		axis_job_t [2:0] ax;
	} job_t;

	typedef struct packed {
		logic lo_neg;
		logic hi_neg;
		logic dzero;
		logic oob;
	} axis_side_t;

endpackage

[design/rubst_if.sv]
// Valid/ready channel interfaces for rays and results.
// Depends on rubst_pkg.
interface rubst_ray_if;
	logic              valid;
	logic              ready;
	rubst_pkg::ray_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rubst_res_if;
	logic              valid;
	logic              ready;
	rubst_pkg::res_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/rubst_front.sv]
// Front end: accepts ray beats, forms slab numerators, divisor magnitudes and flags.
// Depends on rubst_pkg and rubst_if.
module rubst_front (
	input  logic               clk,
	input  logic               arst_n,
	rubst_ray_if.sink          ray,
	output logic               job_valid,
	output rubst_pkg::job_t    job,
	input  logic               job_ready
);

	rubst_pkg::job_t job_c;
	rubst_pkg::job_t job_s1;
	logic            v_s1;
	logic            accept;
	logic signed [31:0] org [3];
	logic signed [31:0] dir [3];

	assign org[0] = ray.data.origin_x;
	assign org[1] = ray.data.origin_y;
	assign org[2] = ray.data.origin_z;
	assign dir[0] = ray.data.dir_x;
	assign dir[1] = ray.data.dir_y;
	assign dir[2] = ray.data.dir_z;

	always_comb begin
		logic signed [32:0] o33;
		logic signed [32:0] lo;
		logic signed [32:0] hi;
		logic [32:0] lo_m;
		logic [32:0] hi_m;
		logic [31:0] d_m;
		for (int k = 0; k < 3; k++) begin
			o33 = {org[k][31], org[k]};
			lo = rubst_pkg::BoxLo - o33;
			hi = rubst_pkg::BoxHi - o33;
			lo_m = lo[32] ? -lo : lo;
			hi_m = hi[32] ? -hi : hi;
			d_m = dir[k][31] ? -dir[k] : dir[k];
			job_c.ax[k].lo_mag = lo_m[31:0];
			job_c.ax[k].hi_mag = hi_m[31:0];
			job_c.ax[k].dvs = d_m;
			job_c.ax[k].lo_neg = lo[32] ^ dir[k][31];
			job_c.ax[k].hi_neg = hi[32] ^ dir[k][31];
			job_c.ax[k].dzero = (dir[k] == 32'sd0);
			job_c.ax[k].oob = (o33 < rubst_pkg::BoxLo) || (o33 > rubst_pkg::BoxHi);
		end
	end

	assign ray.ready = !v_s1 || job_ready;
	assign accept = ray.valid && ray.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (job_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_c;
		end
	end

	assign job_valid = v_s1;
	assign job = job_s1;

endmodule

[design/rubst_queue.sv]
// Short queue that decouples the front end from the divider back end.
// Depends on rubst_pkg.
module rubst_queue #(
	parameter int Depth = rubst_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  rubst_pkg::job_t    push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output rubst_pkg::job_t    pop_data,
	input  logic               pop
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	rubst_pkg::job_t mem_q [Depth];
	logic [AddrW-1:0] wr_q;
	logic [AddrW-1:0] rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             push;
	logic             do_pop;

	assign push_ready = (cnt_q != CntW'(Depth));
	assign pop_valid = (cnt_q != '0);
	assign push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

[design/rubst_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Divides a magnitude scaled by the fraction width by a divisor magnitude. Depends on rubst_pkg.
module rubst_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic [rubst_pkg::MagW-1:0]         num_mag,
	input  logic [rubst_pkg::MagW-1:0]         dvs,
	output logic [rubst_pkg::DivSteps-1:0]     quot
);

	localparam int Steps = rubst_pkg::DivSteps;
	localparam int MW = rubst_pkg::MagW;

	logic [MW-1:0]    rem_q [Steps];
	logic [Steps-1:0] num_q [Steps];
	logic [Steps-1:0] quo_q [Steps];
	logic [MW-1:0]    dvs_q [Steps];
	logic [MW-1:0]    rem_d [Steps];
	logic [Steps-1:0] num_d [Steps];
	logic [Steps-1:0] quo_d [Steps];
	logic [MW-1:0]    dvs_d [Steps];

	always_comb begin
		logic [MW-1:0]    prem;
		logic [Steps-1:0] pnum;
		logic [Steps-1:0] pquo;
		logic [MW-1:0]    pdvs;
		logic [MW:0]      t;
		logic             ge;
		logic [MW:0]      diff;
		for (int k = 0; k < Steps; k++) begin
			if (k == 0) begin
				prem = '0;
				pnum = {num_mag, {rubst_pkg::FracW{1'b0}}};
				pquo = '0;
				pdvs = dvs;
			end else begin
				prem = rem_q[k-1];
				pnum = num_q[k-1];
				pquo = quo_q[k-1];
				pdvs = dvs_q[k-1];
			end
			t = {prem, pnum[Steps-1]};
			ge = (t >= {1'b0, pdvs});
			diff = t - {1'b0, pdvs};
			rem_d[k] = ge ? diff[MW-1:0] : t[MW-1:0];
			num_d[k] = {pnum[Steps-2:0], 1'b0};
			quo_d[k] = {pquo[Steps-2:0], ge};
			dvs_d[k] = pdvs;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Steps; k++) begin
				rem_q[k] <= rem_d[k];
				num_q[k] <= num_d[k];
				quo_q[k] <= quo_d[k];
				dvs_q[k] <= dvs_d[k];
			end
		end
	end

	assign quot = quo_q[Steps-1];

endmodule

[design/rubst_back.sv]
// Back end: six slab divisions, saturation, ordering, folding and the result register.
// Depends on rubst_pkg, rubst_if and rubst_div.
module rubst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  rubst_pkg::job_t    job,
	output logic               job_pop,
	rubst_res_if.source        res
);

	localparam int Steps = rubst_pkg::DivSteps;

	logic                 advance;
	logic [Steps-1:0]     v_div_q;
	rubst_pkg::axis_side_t [2:0] side_q [Steps];
	logic [Steps-1:0]     q_lo [3];
	logic [Steps-1:0]     q_hi [3];
	logic                 v_s1;
	logic                 v_s2;
	logic signed [31:0]   tlo_s1 [3];
	logic signed [31:0]   thi_s1 [3];
	rubst_pkg::axis_side_t [2:0] side_s1;
	logic signed [31:0]   t0_s2 [3];
	logic signed [31:0]   t1_s2 [3];
	rubst_pkg::axis_side_t [2:0] side_s2;
	logic                 out_v_q;
	rubst_pkg::res_t      out_q;
	rubst_pkg::res_t      res_c;

	function automatic logic signed [31:0] sat(input logic [Steps-1:0] m, input logic neg);
		logic [31:0] low;
		logic signed [31:0] r;
		low = m[31:0];
		if (!neg) begin
			r = (m > Steps'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(low);
		end else begin
			r = (m > Steps'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(-low);
		end
		return r;
	endfunction

	assign advance = !out_v_q || res.ready;
	assign job_pop = advance && job_valid;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rubst_div u_div_lo (
			.clk    (clk),
			.en     (advance),
			.num_mag(job.ax[a].lo_mag),
			.dvs    (job.ax[a].dvs),
			.quot   (q_lo[a])
		);
		rubst_div u_div_hi (
			.clk    (clk),
			.en     (advance),
			.num_mag(job.ax[a].hi_mag),
			.dvs    (job.ax[a].dvs),
			.quot   (q_hi[a])
		);
	end

	always_comb begin
		logic signed [31:0] entry;
		logic signed [31:0] exitd;
		logic               miss;
		entry = '0;
		exitd = 32'sh7FFF_FFFF;
		miss = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (side_s2[a].dzero) begin
				miss = miss | side_s2[a].oob;
			end else begin
				if (t0_s2[a] > entry) begin
					entry = t0_s2[a];
				end
				if (t1_s2[a] < exitd) begin
					exitd = t1_s2[a];
				end
			end
		end
		if (entry > exitd || exitd < 0) begin
			miss = 1'b1;
		end
		res_c.hit = !miss;
		res_c.hit_distance = miss ? '0 : entry[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_div_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_div_q <= {v_div_q[Steps-2:0], job_valid};
			v_s1 <= v_div_q[Steps-1];
			v_s2 <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < 3; a++) begin
				side_q[0][a].lo_neg <= job.ax[a].lo_neg;
				side_q[0][a].hi_neg <= job.ax[a].hi_neg;
				side_q[0][a].dzero <= job.ax[a].dzero;
				side_q[0][a].oob <= job.ax[a].oob;
			end
			for (int k = 1; k < Steps; k++) begin
				side_q[k] <= side_q[k-1];
			end
			side_s1 <= side_q[Steps-1];
			for (int a = 0; a < 3; a++) begin
				tlo_s1[a] <= sat(q_lo[a], side_q[Steps-1][a].lo_neg);
				thi_s1[a] <= sat(q_hi[a], side_q[Steps-1][a].hi_neg);
				t0_s2[a] <= (tlo_s1[a] > thi_s1[a]) ? thi_s1[a] : tlo_s1[a];
				t1_s2[a] <= (tlo_s1[a] > thi_s1[a]) ? tlo_s1[a] : thi_s1[a];
			end
			side_s2 <= side_s1;
			out_q <= res_c;
		end
	end

	assign res.valid = out_v_q;
	assign res.data = out_q;

endmodule

[design/ray_unit_box_slab_test_top.sv]
// Top level of the ray against unit box slab test.
// Depends on rubst_pkg, rubst_if, rubst_front, rubst_queue and rubst_back.
//
// The ray channel takes one beat per ray: origin and direction, signed Q16.16.
// The res channel returns one beat per ray, in order: hit, and the entry
// distance in Q15.16, which is zero on a miss. Both use valid and ready.
// A ray is taken every cycle while the result side keeps up; the rate is set
// by the six pipelined dividers, which produce one quotient bit per stage.
// From ray beat to result beat, when nothing stalls, a ray passes through
// one front register, the queue, 48 divider stages, then saturation,
// ordering and the result register.
// When the receiver holds ready low while a result waits, the whole back
// pipeline freezes, the queue fills, and only then does the ray channel drop
// ready; a finished result stays in the result register until taken.
// Reset clears all valid bits and the queue; no clearing pass is needed.
module ray_unit_box_slab_test_top #(
	parameter int QueueDepth = rubst_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	rubst_ray_if.sink  ray,
	rubst_res_if.source res
);

	logic            f_valid;
	rubst_pkg::job_t f_job;
	logic            f_ready;
	logic            q_valid;
	rubst_pkg::job_t q_job;
	logic            q_pop;

	rubst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ray      (ray),
		.job_valid(f_valid),
		.job      (f_job),
		.job_ready(f_ready)
	);

	rubst_queue #(.Depth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_data (f_job),
		.push_ready(f_ready),
		.pop_valid (q_valid),
		.pop_data  (q_job),
		.pop       (q_pop)
	);

	rubst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(q_valid),
		.job      (q_job),
		.job_pop  (q_pop),
		.res      (res)
	);

endmodule

[design/rubst_chk.sv]
// Port checker for the slab test top level, attached by bind.
// Depends on rubst_pkg.
module rubst_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input rubst_pkg::res_t out_data
);

	logic [7:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result beat changed while stalled.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_distance == '0)
		else $error("Miss reported with a nonzero distance.");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("Result beat without an outstanding ray.");

endmodule

bind ray_unit_box_slab_test_top rubst_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (ray.valid),
	.in_ready (ray.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.out_data (res.data)
);
